// File: hw/rtl/spa_pkg.sv
// Shared types and constants of the scattering phase amplitude block.
package spa_pkg;

	// CORDIC datapath width: Q2.30 magnitudes and turn angles with headroom.
	localparam int CW = 34;

	// floor(2^64 / (2*pi)): turns a Q24.40 phase in radians into turns.
	localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

	// Reciprocal of the limit gain of the rotation, Q2.30.
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam int CFG_IDX_W = 3;

	// atan(2^-i) in units of 2^-32 turn, rounded to nearest.
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_Q_X    = 3'd0,
		REG_Q_Y    = 3'd1,
		REG_Q_Z    = 3'd2,
		REG_FACTOR = 3'd3
	} reg_idx_t;

	// Sideband that travels with every pipeline stage.
	typedef struct packed {
		logic valid;
		logic last;
		logic flip;
	} tag_t;

endpackage

// File: hw/rtl/scattering_phase_amplitude.sv
// Top level of the scattering phase amplitude block: s * exp(i * q.r).
//
// Usage: each transfer on the input channel (in_valid/in_ready) carries one
// atom position coord_x/y/z in signed Q16.16 and a last-frame mark. Each one
// produces exactly one transfer on the output channel (out_valid/out_ready)
// with amp_real = s*cos(q.r) and amp_imag = s*sin(q.r), signed Q8.24 and
// saturated, plus result_last copied from frame_last.
// The scattering vector q and the factor s are written through the plain
// write port (cfg_we, cfg_index, cfg_data) while the block is idle; writes
// to indexes above the last register are ignored.
// Throughput is one item per clock while the receiver does not stall the
// output. From the input transfer to out_valid an item passes five dot
// product and turn scaling stages, one stage per CORDIC iteration, a sign
// stage, a multiply stage and the output register.
// Reset clears every valid bit and loads q = 0 and s = 1.0.
// When the receiver stalls, the output register holds its result and one
// more result lands in a skid register; only then does in_ready drop and
// the whole pipeline freezes, so nothing is lost or repeated.
module scattering_phase_amplitude
	import spa_pkg::*;
#(
	parameter int CORDIC_STAGES = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   coord_x,
	input  logic signed [31:0]   coord_y,
	input  logic signed [31:0]   coord_z,
	input  logic                 frame_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   amp_real,
	output logic signed [31:0]   amp_imag,
	output logic                 result_last
);

	// Configuration registers.
	logic signed [31:0] q_x_q, q_y_q, q_z_q, factor_q;

	// Global pipeline advance: the pipeline only freezes once the skid is full.
	logic en;

	tag_t                 ph_tag, cd_tag;
	logic signed [CW-1:0] ph_z;
	logic signed [CW-1:0] cd_x, cd_y;

	// Sign stage and multiply stage after the CORDIC.
	tag_t               tag_s1, tag_s2;
	logic signed [31:0] re_s1, im_s1;
	logic signed [63:0] pr_re_s2, pr_im_s2;

	logic signed [CW-1:0] x_sign, y_sign;
	logic signed [31:0]   re_rnd, im_rnd;
	logic                 arrive;

	// Output register and skid register.
	logic               out_valid_q, skid_valid_q;
	logic signed [31:0] out_re_q, out_im_q, skid_re_q, skid_im_q;
	logic               out_last_q, skid_last_q;

	// Round half up at bit 30 and saturate to the signed 32-bit range.
	function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
		logic signed [64:0] s;
		logic [34:0]        r;
		s = 65'(p) + 65'sd536870912;
		r = s[64:30];
		if (!r[34] && (r[33:31] != 3'b000)) begin
			round_sat = 32'sh7FFFFFFF;
		end else if (r[34] && (r[33:31] != 3'b111)) begin
			round_sat = 32'sh80000000;
		end else begin
			round_sat = r[31:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_x_q    <= '0;
			q_y_q    <= '0;
			q_z_q    <= '0;
			factor_q <= 32'sd16777216;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_Q_X:    q_x_q    <= cfg_data;
				REG_Q_Y:    q_y_q    <= cfg_data;
				REG_Q_Z:    q_z_q    <= cfg_data;
				REG_FACTOR: factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign in_ready = en;

	spa_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.frame_last (frame_last),
		.q_x        (q_x_q),
		.q_y        (q_y_q),
		.q_z        (q_z_q),
		.tag_out    (ph_tag),
		.z_out      (ph_z)
	);

	spa_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (ph_tag),
		.z_in    (ph_z),
		.tag_out (cd_tag),
		.x_out   (cd_x),
		.y_out   (cd_y)
	);

	// Undo the half-turn fold. The rotated vector stays well inside +/-2.0,
	// so the Q2.30 result fits in 32 bits.
	assign x_sign = cd_tag.flip ? -cd_x : cd_x;
	assign y_sign = cd_tag.flip ? -cd_y : cd_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= cd_tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_s1    <= x_sign[31:0];
			im_s1    <= y_sign[31:0];
			pr_re_s2 <= factor_q * re_s1;
			pr_im_s2 <= factor_q * im_s1;
		end
	end

	assign re_rnd = round_sat(pr_re_s2);
	assign im_rnd = round_sat(pr_im_s2);

	// A finished result leaves the pipeline in every cycle the pipeline moves.
	assign arrive = tag_s2.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (arrive) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= arrive;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (arrive) begin
				skid_re_q   <= re_rnd;
				skid_im_q   <= im_rnd;
				skid_last_q <= tag_s2.last;
			end
		end else if (skid_valid_q) begin
			out_re_q   <= skid_re_q;
			out_im_q   <= skid_im_q;
			out_last_q <= skid_last_q;
		end else begin
			out_re_q   <= re_rnd;
			out_im_q   <= im_rnd;
			out_last_q <= tag_s2.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign amp_real    = out_re_q;
	assign amp_imag    = out_im_q;
	assign result_last = out_last_q;

	// The skid only fills behind a waiting output result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	// The skid fills only in a cycle where the output transfer stalled.
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid register filled without an output stall");

	// A draining skid always leaves a valid output result behind it.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> out_valid_q)
		else $error("result lost when the skid register drained");

	// While frozen, the last pipeline stage keeps its result.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s2.valid && skid_valid_q) |=> tag_s2.valid)
		else $error("pipeline result dropped during a stall");

endmodule

// File: hw/rtl/spa_phase.sv
// Phase pipeline: q.r dot product, scaling to turns and half-plane fold.
module spa_phase
	import spa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [31:0]   coord_x,
	input  logic signed [31:0]   coord_y,
	input  logic signed [31:0]   coord_z,
	input  logic                 frame_last,
	input  logic signed [31:0]   q_x,
	input  logic signed [31:0]   q_y,
	input  logic signed [31:0]   q_z,
	output tag_t                 tag_out,
	output logic signed [CW-1:0] z_out
);

	localparam logic [31:0] C0 = INV_TWO_PI[31:0];
	localparam logic [31:0] C1 = INV_TWO_PI[63:32];

	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic signed [63:0]   px_s1, py_s1, pz_s1;
	logic signed [65:0]   sum_s2;
	logic [63:0]          pp00_s3, pp01_s3, pp10_s3, pp11_s3, pp20_s3;
	logic [7:0]           pp21_s3, pp30_s3;
	logic [103:0]         lo_s4;
	logic [39:0]          hi_s4;
	logic signed [CW-1:0] z_s5;

	logic [103:0] sum_ext;
	logic [103:0] lo_sum;
	logic [7:0]   top8;
	logic [39:0]  hi_sum;
	logic [39:0]  hi_total;
	logic [31:0]  turn;
	logic         flip;
	logic [31:0]  z_fold;

	// The dot product is reduced modulo 2^104 before scaling; only turn bits
	// 72 to 103 of the scaled value are kept, so higher bits never matter.
	assign sum_ext = {{38{sum_s2[65]}}, sum_s2};

	assign lo_sum = {40'b0, pp00_s3} + {8'b0, pp01_s3, 32'b0} + {8'b0, pp10_s3, 32'b0};
	assign top8   = pp21_s3 + pp30_s3;
	assign hi_sum = pp11_s3[39:0] + pp20_s3[39:0] + {top8, 32'b0};

	assign hi_total = lo_s4[103:64] + hi_s4;
	assign turn     = hi_total[39:8];
	// Left half plane when the top two bits differ: rotate by half a turn.
	assign flip     = turn[31] ^ turn[30];
	assign z_fold   = {turn[31] ^ flip, turn[30:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (en) begin
			tag_s1 <= '{valid: in_valid, last: frame_last, flip: 1'b0};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= '{valid: tag_s4.valid, last: tag_s4.last, flip: flip};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= coord_x * q_x;
			py_s1   <= coord_y * q_y;
			pz_s1   <= coord_z * q_z;
			sum_s2  <= 66'(px_s1) + 66'(py_s1) + 66'(pz_s1);
			pp00_s3 <= sum_ext[31:0] * C0;
			pp01_s3 <= sum_ext[31:0] * C1;
			pp10_s3 <= sum_ext[63:32] * C0;
			pp11_s3 <= sum_ext[63:32] * C1;
			pp20_s3 <= sum_ext[95:64] * C0;
			pp21_s3 <= sum_ext[71:64] * C1[7:0];
			pp30_s3 <= sum_ext[103:96] * C0[7:0];
			lo_s4   <= lo_sum;
			hi_s4   <= hi_sum;
			z_s5    <= {{(CW-32){z_fold[31]}}, z_fold};
		end
	end

	assign tag_out = tag_s5;
	assign z_out   = z_s5;

endmodule

// File: hw/rtl/spa_cordic.sv
// Rotation-mode CORDIC with one register stage per iteration.
module spa_cordic
	import spa_pkg::*;
#(
	parameter int STAGES = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tag_t                 tag_in,
	input  logic signed [CW-1:0] z_in,
	output tag_t                 tag_out,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out
);

	tag_t                 tag_s [STAGES];
	logic signed [CW-1:0] x_s   [STAGES];
	logic signed [CW-1:0] y_s   [STAGES];
	logic signed [CW-1:0] z_s   [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CW-1:0] xi, yi, zi;
		logic signed [CW-1:0] dx, dy, at;
		logic signed [CW-1:0] xn, yn, zn;
		tag_t                 ti;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
			assign ti = tag_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ti = tag_s[i-1];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;
		assign at = {{(CW-32){1'b0}}, ATAN_TURNS[i]};

		always_comb begin
			if (!zi[CW-1]) begin
				xn = xi - dx;
				yn = yi + dy;
				zn = zi - at;
			end else begin
				xn = xi + dx;
				yn = yi - dy;
				zn = zi + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= ti;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i] <= xn;
				y_s[i] <= yn;
				z_s[i] <= zn;
			end
		end
	end

	assign tag_out = tag_s[STAGES-1];
	assign x_out   = x_s[STAGES-1];
	assign y_out   = y_s[STAGES-1];

endmodule

// File: tb/tb_scattering_phase_amplitude.sv
// Self-checking testbench for the scattering phase amplitude block.
`timescale 1ns / 100ps

module tb_scattering_phase_amplitude;
	import spa_pkg::*;

	localparam int STAGES = 24;
	// Pipeline registers from the input transfer to out_valid.
	localparam int LATENCY = STAGES + 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 250;

	// Register indexes past the last register; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_5  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Handy Q8.24 and Q16.16 values.
	localparam logic [31:0] ONE_Q824  = 32'h0100_0000;
	localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
	localparam int PI_Q1616      = 205887;
	localparam int HALF_PI_Q1616 = 102944;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} position_t;

	typedef struct {
		logic signed [31:0] amp_re;
		logic signed [31:0] amp_im;
		logic               last;
	} amplitude_t;

	// Ways in which the receiver throttles the output channel.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_CHOKED
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [31:0]   coord_x = '0;
	logic signed [31:0]   coord_y = '0;
	logic signed [31:0]   coord_z = '0;
	logic                 frame_last = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   amp_real;
	logic signed [31:0]   amp_imag;
	logic                 result_last;

	scattering_phase_amplitude #(
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.amp_real(amp_real),
		.amp_imag(amp_imag),
		.result_last(result_last)
	);

	// Positions waiting to be sent, and amplitudes waiting to come back.
	position_t  positions_pending[$];
	amplitude_t amplitudes_due[$];

	// Our own copy of the block's registers, loaded as the reset values.
	logic signed [31:0] q_vec[3] = '{32'sd0, 32'sd0, 32'sd0};
	logic signed [31:0] factor = 32'sd16777216;

	int errors = 0;
	int cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Scales a Q2.30 trig value by the Q8.24 factor, rounding ties up and
	// clamping to the 32-bit output range.
	function automatic logic signed [31:0] scale_by_factor(longint f, longint trig);
		longint prod;
		prod = (f * trig + (longint'(1) << 29)) >>> 30;
		if (prod > longint'(32'sh7FFF_FFFF))
			prod = longint'(32'sh7FFF_FFFF);
		if (prod < -(longint'(1) << 31))
			prod = -(longint'(1) << 31);
		return prod[31:0];
	endfunction

	// Expected amplitude for one position under the current register copy.
	function automatic amplitude_t phase_amplitude(position_t pos);
		logic signed [31:0]  c[3];
		logic signed [63:0]  prod;
		logic [127:0]        turns_acc;
		logic [31:0]         turn;
		logic                flip;
		longint              ang, cx, cy, dx, dy;
		amplitude_t          res;
		c[0] = pos.x;
		c[1] = pos.y;
		c[2] = pos.z;
		turns_acc = '0;
		// q.r in Q24.40 radians, times 1/(2*pi), summed modulo 2^128.
		for (int k = 0; k < 3; k++) begin
			prod = c[k] * q_vec[k];
			turns_acc = turns_acc + ({{64{prod[63]}}, prod} * {64'd0, INV_TWO_PI});
		end
		turn = turns_acc[103:72];
		// Angles in the left half plane are turned by half a turn and the
		// rotation result is negated afterwards.
		flip = turn[31] ^ turn[30];
		if (flip)
			turn[31] = ~turn[31];
		ang = longint'($signed(turn));
		cx = longint'(CORDIC_GAIN);
		cy = 0;
		for (int i = 0; i < STAGES && i < 32; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (ang >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				ang = ang - longint'(ATAN_TURNS[i]);
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				ang = ang + longint'(ATAN_TURNS[i]);
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		res.amp_re = scale_by_factor(longint'(factor), cx);
		res.amp_im = scale_by_factor(longint'(factor), cy);
		res.last = pos.last;
		return res;
	endfunction

	// Register write through the plain write port. The block is idle whenever
	// this is called, so updating our copy at the same edge is safe.
	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_Q_X:    q_vec[0] = val;
			REG_Q_Y:    q_vec[1] = val;
			REG_Q_Z:    q_vec[2] = val;
			REG_FACTOR: factor = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_setup(input logic [31:0] qx, input logic [31:0] qy,
			input logic [31:0] qz, input logic [31:0] f);
		set_register(REG_Q_X, qx);
		set_register(REG_Q_Y, qy);
		set_register(REG_Q_Z, qz);
		set_register(REG_FACTOR, f);
	endtask

	task automatic add_position(input int x, input int y, input int z, input logic last);
		position_t pos;
		pos.x = x;
		pos.y = y;
		pos.z = z;
		pos.last = last;
		positions_pending = {positions_pending, pos};
	endtask

	// Hold the sender back until every queued position has gone out and every
	// expected amplitude has come back, then let the pipeline settle. Polling
	// on the falling edge keeps this clear of the edge-time updates.
	task automatic drain_pipeline();
		while (positions_pending.size() != 0 || in_valid || amplitudes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Coordinates: mostly a realistic box of about +-128 angstrom, some full
	// range words so every bit toggles, and now and then an extreme value.
	function automatic int random_coord();
		case ($urandom_range(0, 9))
			0, 1: return int'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return int'(WORD_MAX);
					1: return int'(WORD_MIN);
					2: return int'(WORD_ONES);
					default: return 0;
				endcase
			end
			default: return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	// Scattering vector components: mostly within +-4 per angstrom, with
	// zero and full range words mixed in.
	function automatic logic [31:0] random_q();
		case ($urandom_range(0, 7))
			0: return '0;
			1, 2: return $urandom;
			default: return int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
		endcase
	endfunction

	function automatic logic [31:0] random_factor();
		case ($urandom_range(0, 5))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return $urandom;
			default: return int'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
		endcase
	endfunction

	// Driver. The sender works in bursts of random length separated by random
	// gaps; a zero gap gives long stretches of back-to-back transfers. The
	// expected amplitude is computed from the values on the wires at the
	// accepting edge, so it always matches what the block actually took.
	int burst_left;
	int gap_left;
	position_t next_pos;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			coord_x <= '0;
			coord_y <= '0;
			coord_z <= '0;
			frame_last <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				amplitudes_due = {amplitudes_due, phase_amplitude(
					position_t'{coord_x, coord_y, coord_z, frame_last})};
			// A new position may only be presented once the current one is
			// gone; while a transfer is pending the payload stays put.
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (positions_pending.size() != 0) begin
					next_pos = positions_pending.pop_front();
					coord_x <= next_pos.x;
					coord_y <= next_pos.y;
					coord_z <= next_pos.z;
					frame_last <= next_pos.last;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every output transfer is compared with the oldest expected
	// amplitude. The receiver switches between throttling modes on its own
	// schedule: always ready, coin flips, a fixed duty cycle, and a mostly
	// stalled mode that fills the skid buffer and stops the pipeline.
	rx_mode_t rx_mode;
	int rx_hold;
	int rx_tick;
	amplitude_t got_due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_hold <= 0;
			rx_tick <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (amplitudes_due.size() == 0) begin
					$display("%0t: result with nothing expected: actual re=%h im=%h last=%b",
						$time, amp_real, amp_imag, result_last);
					errors++;
				end else begin
					got_due = amplitudes_due.pop_front();
					if (amp_real !== got_due.amp_re) begin
						$display("%0t: amp_real expected %h actual %h",
							$time, got_due.amp_re, amp_real);
						errors++;
					end
					if (amp_imag !== got_due.amp_im) begin
						$display("%0t: amp_imag expected %h actual %h",
							$time, got_due.amp_im, amp_imag);
						errors++;
					end
					if (result_last !== got_due.last) begin
						$display("%0t: result_last expected %b actual %b",
							$time, got_due.last, result_last);
						errors++;
					end
				end
			end
			rx_tick <= rx_tick + 1;
			if (rx_hold <= 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_hold <= $urandom_range(20, 120);
			end else begin
				rx_hold <= rx_hold - 1;
			end
			case (rx_mode)
				RX_OPEN:     out_ready <= 1'b1;
				RX_COIN:     out_ready <= $urandom_range(0, 1);
				RX_PERIODIC: out_ready <= (rx_tick % 4) != 0;
				default:     out_ready <= (rx_tick % 16) < 3;
			endcase
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("scattering_phase_amplitude regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset values: q = 0 gives phase zero, so every position must come
		// back as exactly the factor 1.0 times cos 0, whatever its size.
		add_position(0, 0, 0, 1'b0);
		add_position(int'(WORD_MAX), int'(WORD_MAX), int'(WORD_MAX), 1'b1);
		add_position(int'(WORD_MIN), int'(WORD_MIN), int'(WORD_MIN), 1'b0);
		add_position(-1, 1, -1, 1'b1);
		drain_pipeline();

		// Writes to indexes beyond the register file must leave q and the
		// factor untouched, so the next positions still see phase zero.
		set_register(REG_SPARE_LO, WORD_MAX);
		set_register(REG_SPARE_5, ONE_Q824);
		set_register(REG_SPARE_6, WORD_MIN);
		set_register(REG_SPARE_HI, WORD_ONES);
		add_position(PI_Q1616, HALF_PI_Q1616, -PI_Q1616, 1'b0);
		add_position(int'(WORD_MAX), 0, int'(WORD_MIN), 1'b1);
		drain_pipeline();

		// q = (1, 0, 0): coord_x is the phase in radians, so the quarter
		// turns land on each axis and both half planes are covered.
		set_setup(ONE_Q824, '0, '0, ONE_Q824);
		add_position(0, 5, 7, 1'b0);
		add_position(HALF_PI_Q1616, 0, 0, 1'b0);
		add_position(PI_Q1616, 0, 0, 1'b1);
		add_position(-HALF_PI_Q1616, 0, 0, 1'b0);
		add_position(3 * HALF_PI_Q1616, 0, 0, 1'b0);
		add_position(4 * HALF_PI_Q1616, 0, 0, 1'b1);
		drain_pipeline();

		// Most negative factor against cos(pi) of about -1.0 pushes the
		// product to the top of the range, where it must saturate.
		set_register(REG_FACTOR, WORD_MIN);
		add_position(PI_Q1616, 0, 0, 1'b0);
		add_position(0, 0, 0, 1'b1);
		add_position(HALF_PI_Q1616, 0, 0, 1'b0);
		drain_pipeline();
		set_register(REG_FACTOR, WORD_MAX);
		add_position(PI_Q1616, 0, 0, 1'b1);
		add_position(-HALF_PI_Q1616, 0, 0, 1'b0);
		drain_pipeline();

		// Extreme q with extreme positions: the phase wraps many turns.
		set_setup(WORD_MAX, WORD_MAX, WORD_MAX, ONE_Q824);
		add_position(int'(WORD_MAX), int'(WORD_MAX), int'(WORD_MAX), 1'b0);
		add_position(int'(WORD_MIN), int'(WORD_MAX), int'(WORD_MIN), 1'b1);
		drain_pipeline();
		set_setup(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		add_position(int'(WORD_MIN), int'(WORD_MIN), int'(WORD_MIN), 1'b0);
		add_position(int'(WORD_MAX), int'(WORD_ONES), 1, 1'b1);
		drain_pipeline();

		// Random phases: a fresh setup each time, written only after the
		// pipeline has drained, followed by a block of random positions.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				set_setup(WORD_MAX, WORD_MIN, ONE_Q824, WORD_MAX);
			else
				set_setup(random_q(), random_q(), random_q(), random_factor());
			if ($urandom_range(0, 1))
				set_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					$urandom);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				add_position(random_coord(), random_coord(), random_coord(),
					$urandom_range(0, 7) == 0);
			drain_pipeline();
		end

		// Everything is back; give stray results time to show up.
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0)
			$display("scattering_phase_amplitude regression: pass");
		else
			$display("scattering_phase_amplitude regression: fail");
		$finish;
	end

endmodule
